[hdl/e8lrd_pkg.sv]
// ----------------------------------------------------------------------------
// E8 lattice reconciliation decoder package
// Shared widths, constants and types for the lane, coset and merge stages.
// ----------------------------------------------------------------------------
package e8lrd_pkg;

	// Ring modulus and derived widths
	localparam int unsigned MODULUS = 12289;
	localparam int unsigned HALF_Q  = MODULUS >> 1;
	localparam int unsigned Q_W     = $clog2(MODULUS);
	localparam int unsigned CODE_W  = 5;
	localparam int unsigned SEC_W   = 14;
	localparam int unsigned ROUND   = 16;
	localparam int unsigned PROD_W  = CODE_W + Q_W;
	localparam int unsigned V_W     = Q_W + 3;
	localparam int unsigned DIST_W  = $clog2(HALF_Q + 1);
	localparam int unsigned COST_W  = 2 * DIST_W;
	localparam int unsigned PAIR_W  = COST_W + 1;
	localparam int unsigned TOTAL_W = PAIR_W + 2;

	// Item geometry
	localparam int unsigned LANES     = 8;
	localparam int unsigned PAIRS     = LANES / 2;
	localparam int unsigned PIDX_W    = $clog2(PAIRS);
	localparam int unsigned HALF_LN   = LANES / 2;
	localparam int unsigned NIB_W     = 4;

	// Per-lane squared distances to 0 and to q/2
	typedef struct packed {
		logic [COST_W-1:0] c0;
		logic [COST_W-1:0] c1;
	} cost_t;

	// Result of one D8 coset decoder
	typedef struct packed {
		logic [PAIRS-1:0]   msg;
		logic [TOTAL_W-1:0] total;
	} d8_res_t;

	// Load enables of the pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

[hdl/e8lrd_lane.sv]
// ----------------------------------------------------------------------------
// E8 decoder lane
// Rebuilds one coefficient mod q from its code and secret, then squares its
// distances to 0 and to q/2. Two pipeline stages.
// ----------------------------------------------------------------------------
module e8lrd_lane (
	input  logic                       clk,
	input  e8lrd_pkg::stage_en_t       en,
	input  logic [e8lrd_pkg::CODE_W-1:0] code,
	input  logic [e8lrd_pkg::SEC_W-1:0]  secret,
	output e8lrd_pkg::cost_t           cost
);
	import e8lrd_pkg::*;

	logic [PROD_W-1:0] rnd;
	logic [Q_W-1:0]    a;
	logic [V_W-1:0]    v;
	logic [Q_W-1:0]    x_d;
	logic [Q_W-1:0]    x_s1;
	logic [DIST_W-1:0] d0;
	logic [DIST_W-1:0] dh;
	cost_t             cost_s2;

	// Rebuild the lane value and fold it into 0..q-1
	always_comb begin
		rnd = PROD_W'(code) * PROD_W'(MODULUS) + PROD_W'(ROUND);
		a   = Q_W'(rnd >> CODE_W);
		v   = V_W'(a) + V_W'(MODULUS) - V_W'(secret);
		if (v[V_W-1]) begin
			x_d = Q_W'(v + V_W'(MODULUS));
		end else if (v >= V_W'(MODULUS)) begin
			x_d = Q_W'(v - V_W'(MODULUS));
		end else begin
			x_d = Q_W'(v);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			x_s1 <= x_d;
		end
	end

	// Distances to 0 and to q/2
	always_comb begin
		if ((Q_W + 1)'({x_s1, 1'b0}) > (Q_W + 1)'(MODULUS)) begin
			d0 = DIST_W'(Q_W'(MODULUS) - x_s1);
		end else begin
			d0 = DIST_W'(x_s1);
		end
		if (x_s1 >= Q_W'(HALF_Q)) begin
			dh = DIST_W'(x_s1 - Q_W'(HALF_Q));
		end else begin
			dh = DIST_W'(Q_W'(HALF_Q) - x_s1);
		end
	end

	// Square both distances
	always_ff @(posedge clk) begin
		if (en.s2) begin
			cost_s2.c0 <= COST_W'(d0) * COST_W'(d0);
			cost_s2.c1 <= COST_W'(dh) * COST_W'(dh);
		end
	end

	assign cost = cost_s2;

endmodule

[hdl/e8lrd_d8.sv]
// ----------------------------------------------------------------------------
// E8 decoder D8 coset stage
// Picks the cheaper alternative per lane pair, then fixes odd parity by
// flipping the pair with the smallest cost gap. Two pipeline stages.
// ----------------------------------------------------------------------------
module e8lrd_d8 (
	input  logic                                 clk,
	input  e8lrd_pkg::stage_en_t                 en,
	input  logic                                 shifted,
	input  e8lrd_pkg::cost_t [e8lrd_pkg::LANES-1:0] costs,
	output e8lrd_pkg::d8_res_t                   res
);
	import e8lrd_pkg::*;

	logic [PAIR_W-1:0]  a0 [PAIRS];
	logic [PAIR_W-1:0]  a1 [PAIRS];
	logic [PAIRS-1:0]   pick_d;
	logic [PAIR_W-1:0]  diff_d [PAIRS];
	logic [PAIR_W-1:0]  best_d [PAIRS];

	logic [PAIRS-1:0]   pick_s3;
	logic [PAIR_W-1:0]  diff_s3 [PAIRS];
	logic [PAIR_W-1:0]  best_s3 [PAIRS];

	logic               lo_sel;
	logic               hi_sel;
	logic [PAIR_W-1:0]  lo_diff;
	logic [PAIR_W-1:0]  hi_diff;
	logic [PIDX_W-1:0]  lo_idx;
	logic [PIDX_W-1:0]  hi_idx;
	logic [PIDX_W-1:0]  min_idx;
	logic [PAIR_W-1:0]  best_gap;
	logic [TOTAL_W-1:0] sum_d;

	logic [PAIRS-1:0]   pick_s4;
	logic               parity_s4;
	logic [PIDX_W-1:0]  idx_s4;
	logic [PAIR_W-1:0]  gap_s4;
	logic [TOTAL_W-1:0] sum_s4;

	// Pair sums and per-pair choice
	always_comb begin
		for (int i = 0; i < PAIRS; i++) begin
			if (shifted) begin
				a0[i] = PAIR_W'(costs[2*i].c1) + PAIR_W'(costs[2*i+1].c0);
				a1[i] = PAIR_W'(costs[2*i].c0) + PAIR_W'(costs[2*i+1].c1);
			end else begin
				a0[i] = PAIR_W'(costs[2*i].c0) + PAIR_W'(costs[2*i+1].c0);
				a1[i] = PAIR_W'(costs[2*i].c1) + PAIR_W'(costs[2*i+1].c1);
			end
			pick_d[i] = (a1[i] < a0[i]);
			diff_d[i] = pick_d[i] ? (a0[i] - a1[i]) : (a1[i] - a0[i]);
			best_d[i] = pick_d[i] ? a1[i] : a0[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			pick_s3 <= pick_d;
			for (int i = 0; i < PAIRS; i++) begin
				diff_s3[i] <= diff_d[i];
				best_s3[i] <= best_d[i];
			end
		end
	end

	// Smallest gap, lowest pair index on ties; total of the chosen costs
	always_comb begin
		lo_sel   = (diff_s3[1] < diff_s3[0]);
		hi_sel   = (diff_s3[3] < diff_s3[2]);
		lo_diff  = lo_sel ? diff_s3[1] : diff_s3[0];
		hi_diff  = hi_sel ? diff_s3[3] : diff_s3[2];
		lo_idx   = lo_sel ? PIDX_W'(1) : PIDX_W'(0);
		hi_idx   = hi_sel ? PIDX_W'(3) : PIDX_W'(2);
		best_gap = (hi_diff < lo_diff) ? hi_diff : lo_diff;
		min_idx  = (hi_diff < lo_diff) ? hi_idx : lo_idx;
		sum_d    = TOTAL_W'(best_s3[0]) + TOTAL_W'(best_s3[1])
		         + TOTAL_W'(best_s3[2]) + TOTAL_W'(best_s3[3]);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			pick_s4   <= pick_s3;
			parity_s4 <= ^pick_s3;
			idx_s4    <= min_idx;
			gap_s4    <= best_gap;
			sum_s4    <= sum_d;
		end
	end

	// Flip the cheapest pair on odd parity
	always_comb begin
		if (parity_s4) begin
			res.msg   = pick_s4 ^ (PAIRS'(1) << idx_s4);
			res.total = sum_s4 + TOTAL_W'(gap_s4);
		end else begin
			res.msg   = pick_s4;
			res.total = sum_s4;
		end
	end

endmodule

[hdl/e8lrd_merge.sv]
// ----------------------------------------------------------------------------
// E8 decoder merge stage
// Selects the cheaper coset and maps its message to the key nibble.
// ----------------------------------------------------------------------------
module e8lrd_merge (
	input  logic                           clk,
	input  e8lrd_pkg::stage_en_t           en,
	input  e8lrd_pkg::d8_res_t             res0,
	input  e8lrd_pkg::d8_res_t             res1,
	output logic [e8lrd_pkg::NIB_W-1:0]    key_nibble
);
	import e8lrd_pkg::*;

	logic             sel;
	logic [PAIRS-1:0] m;
	logic [NIB_W-1:0] nib_d;
	logic [NIB_W-1:0] nibble_s5;

	// Coset 0 wins ties
	always_comb begin
		sel   = (res1.total < res0.total);
		m     = sel ? res1.msg : res0.msg;
		nib_d = {m[3], m[1] ^ m[0], m[0], sel};
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			nibble_s5 <= nib_d;
		end
	end

	assign key_nibble = nibble_s5;

endmodule

[hdl/e8_lattice_reconciliation_decoder_top.sv]
// ----------------------------------------------------------------------------
// Stages from input beat to out_valid: lane value, square, pair choice,
//   gap search and sum, coset select into the output register.
// Throughput: one beat per cycle while out_ready holds; each stage holds one
//   beat and moves on as soon as the stage after it is free or draining.
// Reset: arst_n clears the stage valid bits only; no item state survives.
// ----------------------------------------------------------------------------
// E8 lattice reconciliation decoder top level
// Eight parallel lanes feed two D8 coset decoders and a merge stage.
// ----------------------------------------------------------------------------
module e8_lattice_reconciliation_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [39:0] code_group,
	input  logic [55:0] secret_low,
	input  logic [55:0] secret_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  key_nibble
);
	import e8lrd_pkg::*;

	logic                  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                  rdy1, rdy2, rdy3, rdy4, rdy5;
	stage_en_t             en;
	cost_t [LANES-1:0]     costs;
	d8_res_t               res0;
	d8_res_t               res1;

	// Each stage loads when empty or when its beat moves on
	always_comb begin
		rdy5  = !valid_s5 || out_ready;
		rdy4  = !valid_s4 || rdy5;
		rdy3  = !valid_s3 || rdy4;
		rdy2  = !valid_s2 || rdy3;
		rdy1  = !valid_s1 || rdy2;
		en.s1 = rdy1;
		en.s2 = rdy2;
		en.s3 = rdy3;
		en.s4 = rdy4;
		en.s5 = rdy5;
	end

	assign in_ready  = rdy1;
	assign out_valid = valid_s5;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// Lanes
	for (genvar j = 0; j < LANES; j++) begin : g_lane
		logic [SEC_W-1:0] sec;
		if (j < HALF_LN) begin : g_lo
			assign sec = secret_low[SEC_W*j +: SEC_W];
		end else begin : g_hi
			assign sec = secret_high[SEC_W*(j-HALF_LN) +: SEC_W];
		end
		e8lrd_lane u_lane (
			.clk    (clk),
			.en     (en),
			.code   (code_group[CODE_W*j +: CODE_W]),
			.secret (sec),
			.cost   (costs[j])
		);
	end

	// Coset decoders
	e8lrd_d8 u_d8_c0 (
		.clk     (clk),
		.en      (en),
		.shifted (1'b0),
		.costs   (costs),
		.res     (res0)
	);

	e8lrd_d8 u_d8_c1 (
		.clk     (clk),
		.en      (en),
		.shifted (1'b1),
		.costs   (costs),
		.res     (res1)
	);

	// Coset select and nibble
	e8lrd_merge u_merge (
		.clk        (clk),
		.en         (en),
		.res0       (res0),
		.res1       (res1),
		.key_nibble (key_nibble)
	);

	// An accepted beat lands in the first stage
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted beat missing from first stage");

	// Input stalls only when every stage is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5)
		else $error("input stalled with a bubble in the pipeline");

	// An empty output stage always takes the beat ahead of it
	a_bubble_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !valid_s5 |=> valid_s5)
		else $error("output stage failed to take a waiting beat");

	// A taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && out_ready && !valid_s4 |=> !valid_s5)
		else $error("result repeated after being taken");

endmodule

[dv/tb_e8_lattice_reconciliation_decoder_top.sv]
// ----------------------------------------------------------------------------
// E8 lattice reconciliation decoder testbench
// Drives groups of eight codes and secrets through the valid/ready input with
// bursty timing, stalls the output on a rotating mask, and checks every key
// nibble against an in-bench decode of the same group or a hand-typed nibble. A short table of
// directed groups comes first, then targeted and fully random groups.
// ----------------------------------------------------------------------------
module tb_e8_lattice_reconciliation_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	import e8lrd_pkg::*;

	localparam longint Q         = longint'(MODULUS);
	localparam longint SEC_MAX   = (longint'(1) << SEC_W) - 1;
	localparam longint FLIP_CAP  = 64'h3FFF_FFFF;
	localparam int     NUM_DIR   = 16;
	localparam int     NUM_RAND  = 1890;
	localparam int     QUIET_MAX = 2000;
	localparam int     TAIL_CYC  = 20;

	// One input group plus an optional hand-typed nibble
	typedef struct packed {
		logic [39:0]      codes;
		logic [55:0]      sec_lo;
		logic [55:0]      sec_hi;
		logic             typed;
		logic [NIB_W-1:0] nibble;
	} group_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [39:0] code_group = '0;
	logic [55:0] secret_low = '0;
	logic [55:0] secret_high = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  key_nibble;

	logic [NIB_W-1:0] pending_nibbles [$];
	int               mismatch_count = 0;
	int               quiet_cycles = 0;
	logic [15:0]      stall_mask = 16'hFFFF;
	logic [3:0]       stall_phase = '0;
	int               stall_left = 0;

	e8_lattice_reconciliation_decoder_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.code_group  (code_group),
		.secret_low  (secret_low),
		.secret_high (secret_high),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_nibble  (key_nibble)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic group_t make_group(input logic [39:0] c, input logic [55:0] lo,
			input logic [55:0] hi, input logic typed, input logic [NIB_W-1:0] nib);
		group_t g;
		g.codes  = c;
		g.sec_lo = lo;
		g.sec_hi = hi;
		g.typed  = typed;
		g.nibble = nib;
		return g;
	endfunction

	// Decode one group: rebuild lanes, cost both cosets, pick and map the nibble
	function automatic logic [NIB_W-1:0] decode_nibble(input group_t g);
		longint           x, v, d, sec;
		longint           near_zero [LANES];
		longint           near_half [LANES];
		longint           a0, a1, gap, best_gap, sum;
		longint           coset_cost [2];
		logic [PAIRS-1:0] coset_msg [2];
		logic [PAIRS-1:0] bits;
		logic [111:0]     secrets;
		logic             pick, par, sel;
		int               j, p, s, best_pair;
		secrets = {g.sec_hi, g.sec_lo};
		for (j = 0; j < LANES; j++) begin
			x   = (longint'(g.codes[CODE_W*j +: CODE_W]) * Q + longint'(ROUND)) >> 5;
			sec = longint'(secrets[SEC_W*j +: SEC_W]);
			v   = (x - sec + Q) % Q;
			if (v < 0)
				v += Q;
			d = (2 * v > Q) ? Q - v : v;
			near_zero[j] = d * d;
			d = (v >= longint'(HALF_Q)) ? v - longint'(HALF_Q) : longint'(HALF_Q) - v;
			near_half[j] = d * d;
		end
		for (s = 0; s < 2; s++) begin
			bits      = '0;
			par       = 1'b0;
			sum       = 0;
			best_gap  = FLIP_CAP;
			best_pair = 0;
			for (p = 0; p < PAIRS; p++) begin
				a0   = (s == 1) ? near_half[2*p] + near_zero[2*p+1]
						: near_zero[2*p] + near_zero[2*p+1];
				a1   = (s == 1) ? near_zero[2*p] + near_half[2*p+1]
						: near_half[2*p] + near_half[2*p+1];
				pick = (a1 < a0);
				gap  = pick ? a0 - a1 : a1 - a0;
				bits[p] = pick;
				par ^= pick;
				sum += pick ? a1 : a0;
				// strict compare keeps the lowest pair on equal gaps
				if (gap < best_gap) begin
					best_gap  = gap;
					best_pair = p;
				end
			end
			// odd parity: flip the cheapest pair
			if (par) begin
				bits[best_pair] = ~bits[best_pair];
				sum += best_gap;
			end
			coset_msg[s]  = bits;
			coset_cost[s] = sum;
		end
		sel  = (coset_cost[1] < coset_cost[0]);
		bits = sel ? coset_msg[1] : coset_msg[0];
		return {bits[3], bits[1] ^ bits[0], bits[0], sel};
	endfunction

	// Random group: some fully random, most with lanes aimed at decision points
	task automatic random_group(output group_t g);
		logic [111:0] secrets;
		logic [4:0]   code;
		longint       base, target, sec;
		int           j;
		g = '0;
		if ($urandom_range(0, 9) < 3) begin
			g.codes  = 40'({$urandom(), $urandom()});
			g.sec_lo = 56'({$urandom(), $urandom()});
			g.sec_hi = 56'({$urandom(), $urandom()});
		end else begin
			secrets = '0;
			for (j = 0; j < LANES; j++) begin
				code = 5'($urandom_range(0, 31));
				base = (longint'(code) * Q + longint'(ROUND)) >> 5;
				case ($urandom_range(0, 6))
					0: target = 0;
					1: target = Q / 4;
					2: target = longint'(HALF_Q);
					3: target = (3 * Q) / 4;
					4: target = longint'(HALF_Q) + 1;
					default: target = longint'($urandom_range(0, MODULUS - 1));
				endcase
				if ($urandom_range(0, 2) != 0)
					target += longint'($urandom_range(0, 48)) - 24;
				sec = (base - target) % Q;
				if (sec < 0)
					sec += Q;
				// push some secrets past the modulus
				if ($urandom_range(0, 4) == 0 && sec + Q <= SEC_MAX)
					sec += Q;
				if ($urandom_range(0, 15) == 0)
					sec = longint'($urandom_range(0, 32'(SEC_MAX)));
				g.codes[CODE_W*j +: CODE_W] = code;
				secrets[SEC_W*j +: SEC_W]   = 14'(sec);
				// copy the previous lane to force equal costs
				if (j > 0 && $urandom_range(0, 4) == 0) begin
					g.codes[CODE_W*j +: CODE_W] = g.codes[CODE_W*(j-1) +: CODE_W];
					secrets[SEC_W*j +: SEC_W]   = secrets[SEC_W*(j-1) +: SEC_W];
				end
			end
			g.sec_lo = secrets[55:0];
			g.sec_hi = secrets[111:56];
		end
	endtask

	// Stimulus: directed table first, then random groups in bursts
	initial begin : stimulus
		group_t dir_tab [NUM_DIR];
		group_t row;
		int     n, burst_left, gap;
		dir_tab[0]  = make_group('0, '0, '0, 1'b1, 4'd0);
		dir_tab[1]  = make_group('1, '1, '1, 1'b0, '0);
		dir_tab[2]  = make_group({LANES{5'd16}}, {4{14'd1}}, {4{14'd1}}, 1'b1, 4'hA);
		dir_tab[3]  = make_group({LANES{5'd8}}, '0, '0, 1'b1, 4'd0);
		dir_tab[4]  = make_group('0, {4{14'd12289}}, {4{14'd12289}}, 1'b1, 4'd0);
		dir_tab[5]  = make_group('0, {4{14'd12288}}, {4{14'd12288}}, 1'b0, '0);
		dir_tab[6]  = make_group('0, '1, '1, 1'b0, '0);
		dir_tab[7]  = make_group('1, '0, '0, 1'b0, '0);
		dir_tab[8]  = make_group(40'h55_5555_5555, 56'hAA_AAAA_AAAA_AAAA,
				56'h55_5555_5555_5555, 1'b0, '0);
		dir_tab[9]  = make_group(40'hAA_AAAA_AAAA, 56'h55_5555_5555_5555,
				56'hAA_AAAA_AAAA_AAAA, 1'b0, '0);
		dir_tab[10] = make_group({30'd0, 5'd16, 5'd16}, {28'd0, 14'd1, 14'd1}, '0,
				1'b0, '0);
		dir_tab[11] = make_group({5'd16, 35'd0}, '0, {14'd1, 42'd0}, 1'b0, '0);
		dir_tab[12] = make_group({LANES{5'd16}}, '0, '0, 1'b0, '0);
		dir_tab[13] = make_group('0, {4{14'd1}}, {4{14'd1}}, 1'b0, '0);
		dir_tab[14] = make_group(40'hFE_DCBA_9876, 56'h12_3456_789A_BCDE,
				56'hFE_DCBA_9876_5432, 1'b0, '0);
		dir_tab[15] = make_group({5'd8, 5'd24, 5'd8, 5'd24, 5'd0, 5'd16, 5'd0, 5'd16},
				{14'd12289, 14'd1, 14'd16383, 14'd1}, {4{14'd3}}, 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = $urandom_range(1, 40);
		for (n = 0; n < NUM_DIR + NUM_RAND; n++) begin
			if (n < NUM_DIR)
				row = dir_tab[n];
			else
				random_group(row);
			in_valid    <= 1'b1;
			code_group  <= row.codes;
			secret_low  <= row.sec_lo;
			secret_high <= row.sec_hi;
			// hold the beat until accepted
			do @(posedge clk); while (!in_ready);
			pending_nibbles.push_back(row.typed ? row.nibble : decode_nibble(row));
			burst_left--;
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 40);
				if ($urandom_range(0, 3) == 0)
					gap = 0;
				else if ($urandom_range(0, 7) == 0)
					gap = $urandom_range(5, 20);
				else
					gap = $urandom_range(1, 4);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;

		// drain, then watch for stray beats
		while (pending_nibbles.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Output stall: rotate a mask, swap it now and then; bit 0 caps stall length
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
			stall_left <= $urandom_range(16, 256);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= stall_phase + 4'd1;
		out_ready   <= stall_mask[stall_phase];
	end

	// Check each output beat against the oldest expected nibble
	always @(posedge clk) begin
		logic [NIB_W-1:0] want;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending_nibbles.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, key_nibble=%h", key_nibble));
			end else begin
				want = pending_nibbles.pop_front();
				if (key_nibble !== want)
					report_mismatch($sformatf("key_nibble=%h, want %h", key_nibble, want));
			end
		end
	end

	// Watchdog: too long without any beat on either side
	initial begin : watchdog
		do @(posedge clk); while (quiet_cycles < QUIET_MAX);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
